[rtl/core/oaht_pkg.sv]
// Shared constants, codes and divider handshake types for the open-addressing hash table.
package oaht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W      = 10;
  localparam int SIZE_W      = 11;
  localparam int KEY_W       = 30;
  localparam int COLL_W      = 12;
  localparam int TOT_W       = 32;
  localparam int COEF_W      = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int ACC_W       = 22;
  localparam int RECIP_W     = 31;
  localparam int DEC_SHIFT   = 40;

  // Probe modes.
  localparam logic [1:0] MODE_LINEAR    = 2'd0;
  localparam logic [1:0] MODE_DOUBLE    = 2'd1;
  localparam logic [1:0] MODE_UNIVERSAL = 2'd2;

  // Operations.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW   = 3'd4;

  // Decimal group size for the universal hash.
  localparam logic [SIZE_W-1:0] DEC_GROUP = 11'd1000;

  // Reciprocal of 1000 scaled by 2**40 and rounded up; the quotient it gives
  // is exact for every dividend below 2**30.
  localparam logic [RECIP_W-1:0] DEC_RECIP = 31'd1099511628;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [KEY_W-1:0]  quot;
    logic [SIZE_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/core/oaht_in_if.sv]
// Request channel carrying one table operation.
interface oaht_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [oaht_pkg::KEY_W-1:0] key_value;

  modport source (output valid, operation, key_value, input ready);
  modport sink   (input valid, operation, key_value, output ready);
endinterface

[rtl/core/oaht_out_if.sv]
// Result channel carrying the outcome of one table operation.
interface oaht_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [oaht_pkg::SLOT_W-1:0] slot_index;
  logic [oaht_pkg::COLL_W-1:0] probe_collisions;
  logic [oaht_pkg::TOT_W-1:0]  insert_total;
  logic [oaht_pkg::TOT_W-1:0]  search_total;

  modport source (output valid, hit, slot_index, probe_collisions, insert_total,
                  search_total, input ready);
  modport sink   (input valid, hit, slot_index, probe_collisions, insert_total,
                  search_total, output ready);
endinterface

[rtl/core/oaht_cfg_if.sv]
// Configuration write channel.
interface oaht_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [oaht_pkg::CFG_IDX_W-1:0]  index;
  logic [oaht_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/oaht_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module oaht_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  oaht_pkg::div_req_t req_i,
  output oaht_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(oaht_pkg::KEY_W + 1);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [oaht_pkg::KEY_W-1:0]    quot_q;
  logic [oaht_pkg::SIZE_W-1:0]   rem_q;
  logic [oaht_pkg::SIZE_W-1:0]   divisor_q;
  logic [oaht_pkg::SIZE_W:0]     trial;
  logic                          take;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, quot_q[oaht_pkg::KEY_W-1]};
  assign take  = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(oaht_pkg::KEY_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quot_q    <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[oaht_pkg::KEY_W-2:0], take};
      rem_q  <= take ? oaht_pkg::SIZE_W'(trial - {1'b0, divisor_q})
                     : trial[oaht_pkg::SIZE_W-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/core/open_addressing_hash_table.sv]
// Open-addressing hash table with linear, double and universal probing.
//
// Channels: in_i takes a request (operation, key_value); out_o returns one
// result per request (hit, slot_index, probe_collisions and the two running
// collision totals). cfg_i writes the five registers by index; it is always
// ready, and the user must write it only while the block is idle; the block
// itself does not enforce this. One request is worked at a time; in_i is
// ready only in the idle state. Steps: a divide for key mod size, a second
// one for the double stride, and for universal mode three decimal-group
// steps (two of them reciprocal multiplies), three multiply steps and a
// third divide for the hash; then for each table probe a memory read, then
// a check, and last the result is posted. The shared divider and the slot
// memory set this order of steps.
// After reset a clearing pass marks all 1024 slots empty, one per cycle, so
// in_i stays not ready until it ends; registers return to their reset values.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its own result waits until out_o has been taken.
module open_addressing_hash_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  oaht_in_if.sink       in_i,
  oaht_out_if.source    out_o,
  oaht_cfg_if.sink      cfg_i
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV_SIZE, ST_DIV_STRIDE, ST_DEC0, ST_DEC1, ST_DEC2,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_DIV_HASH, ST_READ, ST_CHECK, ST_DONE
  } state_e;

  localparam int ENTRY_W = oaht_pkg::KEY_W + 1;

  state_e                         state_q;
  logic [1:0]                     mode_cfg_q;
  logic [oaht_pkg::SIZE_W-1:0]    size_cfg_q;
  logic [oaht_pkg::COEF_W-1:0]    coef_high_q, coef_mid_q, coef_low_q;
  logic [oaht_pkg::SIZE_W-1:0]    size_eff;

  logic                           op_q;
  logic [oaht_pkg::KEY_W-1:0]     key_q;
  logic [1:0]                     mode_q;
  logic [oaht_pkg::SIZE_W-1:0]    size_q;
  logic [oaht_pkg::SLOT_W-1:0]    p_q, stride_q, u_q, addr_q, clr_q;
  logic [oaht_pkg::SIZE_W-1:0]    i_q;
  logic [oaht_pkg::COLL_W-1:0]    coll_q;
  logic [oaht_pkg::COEF_W-1:0]    g0_q, g1_q, g2_q;
  logic [oaht_pkg::KEY_W-1:0]     q1_q;
  logic [oaht_pkg::SIZE_W-1:0]    q2_q;
  logic [oaht_pkg::ACC_W-1:0]     acc_q;
  logic                           uni_chk_q;
  logic                           hit_q;
  logic [oaht_pkg::SLOT_W-1:0]    slot_q;
  logic [oaht_pkg::TOT_W-1:0]     ins_tot_q, srch_tot_q;
  logic                           out_valid_q;

  oaht_pkg::div_req_t             div_req_q;
  oaht_pkg::div_rsp_t             div_rsp;
  logic                           div_start_d;

  logic [ENTRY_W-1:0]             mem [oaht_pkg::TABLE_DEPTH];
  logic [ENTRY_W-1:0]             rd_q;
  logic                           mem_we;
  logic [oaht_pkg::SLOT_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]             mem_wdata;
  logic [oaht_pkg::SLOT_W-1:0]    probe_addr;

  logic [oaht_pkg::RECIP_W-1:0]   mul_a;
  logic [oaht_pkg::KEY_W-1:0]     mul_b;
  logic [oaht_pkg::RECIP_W+oaht_pkg::KEY_W-1:0] prod;
  logic [oaht_pkg::SIZE_W-1:0]    p_sum, p_next, i_next;
  logic                           slot_free, slot_match;
  logic [oaht_pkg::COLL_W-1:0]    coll_inc;
  logic [oaht_pkg::TOT_W:0]       ins_sum, srch_sum;

  // Effective table size, clamped to the usable range.
  always_comb begin
    size_eff = size_cfg_q;
    if (size_cfg_q < oaht_pkg::SIZE_W'(2)) begin
      size_eff = oaht_pkg::SIZE_W'(2);
    end else if (size_cfg_q > oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH)) begin
      size_eff = oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH);
    end
  end

  oaht_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // Divider start: raised for one cycle whenever the sequencer needs a divide.
  always_comb begin
    case (state_q)
      ST_IDLE:     div_start_d = in_i.valid;
      ST_DIV_SIZE: div_start_d = div_rsp.done && (mode_q != oaht_pkg::MODE_LINEAR);
      ST_MUL2:     div_start_d = 1'b1;
      default:     div_start_d = 1'b0;
    endcase
  end

  // Shared multiplier: decimal group splitting by reciprocal, then the hash terms.
  always_comb begin
    case (state_q)
      ST_DEC0: begin
        mul_a = oaht_pkg::DEC_RECIP;
        mul_b = key_q;
      end
      ST_DEC1: begin
        mul_a = oaht_pkg::DEC_RECIP;
        mul_b = q1_q;
      end
      ST_MUL0: begin
        mul_a = oaht_pkg::RECIP_W'(coef_high_q);
        mul_b = oaht_pkg::KEY_W'(g0_q);
      end
      ST_MUL1: begin
        mul_a = oaht_pkg::RECIP_W'(coef_mid_q);
        mul_b = oaht_pkg::KEY_W'(g1_q);
      end
      default: begin
        mul_a = oaht_pkg::RECIP_W'(coef_low_q);
        mul_b = oaht_pkg::KEY_W'(g2_q);
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Probe address and stepping along the probe sequence.
  assign probe_addr = uni_chk_q ? u_q : p_q;
  assign p_sum      = {1'b0, p_q} + {1'b0, stride_q};
  assign p_next     = (p_sum >= size_q) ? p_sum - size_q : p_sum;
  assign i_next     = i_q + 1'b1;
  assign slot_free  = !rd_q[oaht_pkg::KEY_W];
  assign slot_match = rd_q[oaht_pkg::KEY_W] && (rd_q[oaht_pkg::KEY_W-1:0] == key_q);
  assign coll_inc   = coll_q + 1'b1;

  // Saturating running totals.
  assign ins_sum  = {1'b0, ins_tot_q} + (oaht_pkg::TOT_W + 1)'(coll_q);
  assign srch_sum = {1'b0, srch_tot_q} + (oaht_pkg::TOT_W + 1)'(coll_q);

  // Slot memory write port: clearing pass or insert.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = {1'b1, key_q};
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == ST_CHECK && op_q == oaht_pkg::OP_INSERT && slot_free) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[probe_addr];
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;

  // Sequencer, configuration registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mode_cfg_q  <= oaht_pkg::MODE_LINEAR;
      size_cfg_q  <= oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH);
      coef_high_q <= '0;
      coef_mid_q  <= '0;
      coef_low_q  <= '0;
      ins_tot_q   <= '0;
      srch_tot_q  <= '0;
      out_valid_q <= 1'b0;
      div_req_q   <= '0;
    end else begin
      div_req_q.start <= div_start_d;
      // A taken result clears the output unless a new one replaces it now.
      if (out_valid_q && out_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      // Register writes.
      if (cfg_i.valid) begin
        case (cfg_i.index)
          oaht_pkg::REG_PROBE_MODE: mode_cfg_q  <= cfg_i.data[1:0];
          oaht_pkg::REG_TABLE_SIZE: size_cfg_q  <= cfg_i.data;
          oaht_pkg::REG_COEF_HIGH:  coef_high_q <= cfg_i.data[oaht_pkg::COEF_W-1:0];
          oaht_pkg::REG_COEF_MID:   coef_mid_q  <= cfg_i.data[oaht_pkg::COEF_W-1:0];
          oaht_pkg::REG_COEF_LOW:   coef_low_q  <= cfg_i.data[oaht_pkg::COEF_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == oaht_pkg::SLOT_W'(oaht_pkg::TABLE_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_i.valid) begin
            op_q               <= in_i.operation;
            key_q              <= in_i.key_value;
            mode_q             <= (mode_cfg_q == oaht_pkg::MODE_DOUBLE ||
                                   mode_cfg_q == oaht_pkg::MODE_UNIVERSAL) ?
                                  mode_cfg_q : oaht_pkg::MODE_LINEAR;
            size_q             <= size_eff;
            coll_q             <= '0;
            div_req_q.dividend <= in_i.key_value;
            div_req_q.divisor  <= size_eff;
            state_q            <= ST_DIV_SIZE;
          end
        end
        ST_DIV_SIZE: begin
          if (div_rsp.done) begin
            p_q       <= div_rsp.rem[oaht_pkg::SLOT_W-1:0];
            i_q       <= '0;
            uni_chk_q <= 1'b0;
            if (mode_q == oaht_pkg::MODE_LINEAR) begin
              stride_q <= oaht_pkg::SLOT_W'(1);
              state_q  <= ST_READ;
            end else begin
              div_req_q.dividend <= key_q;
              div_req_q.divisor  <= size_q - 1'b1;
              state_q            <= ST_DIV_STRIDE;
            end
          end
        end
        ST_DIV_STRIDE: begin
          if (div_rsp.done) begin
            stride_q <= div_rsp.rem[oaht_pkg::SLOT_W-1:0] + 1'b1;
            if (mode_q == oaht_pkg::MODE_UNIVERSAL) begin
              state_q <= ST_DEC0;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        // Key divided by 1000.
        ST_DEC0: begin
          q1_q    <= oaht_pkg::KEY_W'(prod >> oaht_pkg::DEC_SHIFT);
          state_q <= ST_DEC1;
        end
        // Lowest group, and the key divided by 1000000.
        ST_DEC1: begin
          g2_q    <= oaht_pkg::COEF_W'(key_q -
                     q1_q * oaht_pkg::KEY_W'(oaht_pkg::DEC_GROUP));
          q2_q    <= oaht_pkg::SIZE_W'(prod >> oaht_pkg::DEC_SHIFT);
          state_q <= ST_DEC2;
        end
        // Middle group, and the highest group folded back below 1000.
        ST_DEC2: begin
          g1_q    <= oaht_pkg::COEF_W'(q1_q - oaht_pkg::KEY_W'(q2_q) *
                     oaht_pkg::KEY_W'(oaht_pkg::DEC_GROUP));
          g0_q    <= (q2_q >= oaht_pkg::DEC_GROUP) ?
                     oaht_pkg::COEF_W'(q2_q - oaht_pkg::DEC_GROUP) :
                     q2_q[oaht_pkg::COEF_W-1:0];
          state_q <= ST_MUL0;
        end
        ST_MUL0: begin
          acc_q   <= oaht_pkg::ACC_W'(prod);
          state_q <= ST_MUL1;
        end
        ST_MUL1: begin
          acc_q   <= acc_q + oaht_pkg::ACC_W'(prod);
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          div_req_q.dividend <= oaht_pkg::KEY_W'(acc_q + oaht_pkg::ACC_W'(prod));
          div_req_q.divisor  <= size_q;
          state_q            <= ST_DIV_HASH;
        end
        ST_DIV_HASH: begin
          if (div_rsp.done) begin
            u_q       <= div_rsp.rem[oaht_pkg::SLOT_W-1:0];
            uni_chk_q <= 1'b1;
            state_q   <= ST_READ;
          end
        end
        ST_READ: begin
          addr_q  <= probe_addr;
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          state_q <= ST_READ;
          if (op_q == oaht_pkg::OP_INSERT) begin
            if (slot_free) begin
              hit_q   <= 1'b1;
              slot_q  <= addr_q;
              state_q <= ST_DONE;
            end else begin
              coll_q <= coll_inc;
              if (uni_chk_q) begin
                // Hashed slot taken: fall back to a full double walk.
                uni_chk_q <= 1'b0;
              end else if (i_next == size_q) begin
                hit_q   <= 1'b0;
                slot_q  <= '0;
                state_q <= ST_DONE;
              end else begin
                i_q <= i_next;
                p_q <= p_next[oaht_pkg::SLOT_W-1:0];
              end
            end
          end else begin
            if (slot_match) begin
              hit_q   <= 1'b1;
              slot_q  <= addr_q;
              state_q <= ST_DONE;
            end else begin
              coll_q <= coll_inc;
              if (uni_chk_q) begin
                // Hashed slot missed: check this step's double probe.
                uni_chk_q <= 1'b0;
              end else if (i_next == size_q) begin
                hit_q   <= 1'b0;
                slot_q  <= '0;
                state_q <= ST_DONE;
              end else begin
                i_q       <= i_next;
                p_q       <= p_next[oaht_pkg::SLOT_W-1:0];
                uni_chk_q <= (mode_q == oaht_pkg::MODE_UNIVERSAL);
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q            <= 1'b1;
            out_o.hit              <= hit_q;
            out_o.slot_index       <= slot_q;
            out_o.probe_collisions <= coll_q;
            if (op_q == oaht_pkg::OP_INSERT) begin
              ins_tot_q          <= ins_sum[oaht_pkg::TOT_W] ? '1 :
                                    ins_sum[oaht_pkg::TOT_W-1:0];
              out_o.insert_total <= ins_sum[oaht_pkg::TOT_W] ? '1 :
                                    ins_sum[oaht_pkg::TOT_W-1:0];
              out_o.search_total <= srch_tot_q;
            end else begin
              srch_tot_q         <= srch_sum[oaht_pkg::TOT_W] ? '1 :
                                    srch_sum[oaht_pkg::TOT_W-1:0];
              out_o.search_total <= srch_sum[oaht_pkg::TOT_W] ? '1 :
                                    srch_sum[oaht_pkg::TOT_W-1:0];
              out_o.insert_total <= ins_tot_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A new request is never taken back to back.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while a request was in progress");

  // A miss always reports slot zero.
  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.hit) |-> (out_o.slot_index == '0))
    else $error("miss reported with a nonzero slot");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Probing stays within the active table.
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ({1'b0, probe_addr} < size_q))
    else $error("probe address beyond table size");

endmodule
